/* sv/psls_pkg.sv */
// ----------------------------------------------------------------------------
// psls_pkg
// Shared types and constants for the per-source latency statistics block.
// ----------------------------------------------------------------------------
package psls_pkg;

  // Table geometry
  localparam int MAX_SOURCES = 16;
  localparam int SRC_W       = 4;
  localparam int ACT_W       = 5;
  localparam int CNT_W       = 32;
  localparam int DLY_W       = 32;
  localparam int TOT_W       = 64;

  // Request codes
  localparam logic [1:0] REQ_MADE   = 2'd0;
  localparam logic [1:0] REQ_EATEN  = 2'd1;
  localparam logic [1:0] REQ_REPORT = 2'd2;

  // Controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(16);

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SRC_W-1:0] source_index;
    logic [DLY_W-1:0] delay_value;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] made_count;
    logic [CNT_W-1:0] eaten_count;
    logic [DLY_W-1:0] min_delay_out;
    logic [DLY_W-1:0] avg_delay_out;
    logic [DLY_W-1:0] max_delay_out;
    logic             count_mismatch;
    logic             bad_source;
  } rsp_t;

  // One table entry as stored in the statistics memory.
  typedef struct packed {
    logic [CNT_W-1:0] made;
    logic [CNT_W-1:0] eaten;
    logic [TOT_W-1:0] total;
    logic [DLY_W-1:0] min_dly;
    logic [DLY_W-1:0] max_dly;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    made:    '0,
    eaten:   '0,
    total:   '0,
    min_dly: '1,
    max_dly: '0
  };

endpackage

/* sv/psls_ram.sv */
// ----------------------------------------------------------------------------
// psls_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module psls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/psls_div.sv */
// ----------------------------------------------------------------------------
// psls_div
// Restoring divider for the average delay, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psls_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [psls_pkg::TOT_W-1:0]  dividend_i,
  input  logic [psls_pkg::CNT_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [psls_pkg::DLY_W-1:0]  quotient_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [4:0]                 cnt_q, cnt_d;
  logic [psls_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [psls_pkg::DLY_W-1:0] lo_q, lo_d;
  logic [psls_pkg::CNT_W-1:0] dvs_q, dvs_d;
  logic [psls_pkg::CNT_W:0]   trial;
  logic [psls_pkg::CNT_W:0]   diff;
  logic                       fits;

  // The total never exceeds count times the largest delay, so the upper half
  // of the dividend is always below the divisor and 32 steps are enough.
  assign trial = {rem_q, lo_q[psls_pkg::DLY_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[psls_pkg::TOT_W-1:psls_pkg::DLY_W];
      lo_d   = dividend_i[psls_pkg::DLY_W-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[psls_pkg::CNT_W-1:0] : trial[psls_pkg::CNT_W-1:0];
      lo_d  = {lo_q[psls_pkg::DLY_W-2:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = lo_q;

endmodule

/* sv/per_source_latency_stats.sv */
// ----------------------------------------------------------------------------
// per_source_latency_stats
// Per-source produced/consumed counters with min, average and max delay.
// ----------------------------------------------------------------------------
// The block works on one item at a time. A produced or consumed event is a
// statistics memory read followed by the modify and write back, and the input
// stalls until the write back is done. A report for a source that has
// consumed items waits on the 32-step divider that forms the average; a
// report for an inactive source or one with no consumed items goes from the
// read straight to the output state. A finished report waits in an output
// register, and the next item is taken while it waits. The table entries are
// marked valid as they are written, so after reset every entry reads as its
// reset value and no clearing pass is needed.
module per_source_latency_stats (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  psls_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output psls_pkg::rsp_t              out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [psls_pkg::ACT_W-1:0]  cfg_data_i
);

  logic [1:0]                        state_q, state_d;
  logic [psls_pkg::ACT_W-1:0]        act_q;
  logic [psls_pkg::MAX_SOURCES-1:0]  vld_q;
  logic                              hit_q;
  psls_pkg::req_t                    req_q;
  psls_pkg::rsp_t                    res_q, res_d;
  psls_pkg::rsp_t                    out_q;
  logic                              out_valid_q, out_valid_d;

  logic                              in_acc;
  logic                              src_ok;
  logic                              we;
  logic                              load;
  logic                              div_start;
  logic                              div_done;
  logic [psls_pkg::DLY_W-1:0]        quotient;
  logic [psls_pkg::ENTRY_W-1:0]      ram_rdata;
  psls_pkg::entry_t                  cur, nxt;

  assign in_acc      = in_valid_i && (state_q == psls_pkg::S_IDLE);
  assign in_stall_o  = (state_q != psls_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;

  psls_ram #(
    .WIDTH (psls_pkg::ENTRY_W),
    .DEPTH (psls_pkg::MAX_SOURCES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (req_q.source_index),
    .wdata_i (nxt),
    .re_i    (in_acc),
    .raddr_i (in_data_i.source_index),
    .rdata_o (ram_rdata)
  );

  psls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur.total),
    .divisor_i  (cur.eaten),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Entries never written since reset read as the reset value.
  assign cur    = hit_q ? psls_pkg::entry_t'(ram_rdata) : psls_pkg::ENTRY_RESET;
  assign src_ok = ({1'b0, req_q.source_index} < act_q) &&
                  (32'(req_q.source_index) < 32'(psls_pkg::MAX_SOURCES));
  assign load   = (state_q == psls_pkg::S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    nxt       = cur;
    we        = 1'b0;
    div_start = 1'b0;
    res_d     = res_q;
    case (state_q)
      psls_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = psls_pkg::S_READ;
        end
      end
      psls_pkg::S_READ: begin
        state_d = psls_pkg::S_IDLE;
        case (req_q.req_type)
          psls_pkg::REQ_MADE: begin
            if (src_ok) begin
              we = 1'b1;
              if (cur.made != '1) begin
                nxt.made = cur.made + 32'd1;
              end
            end
          end
          psls_pkg::REQ_EATEN: begin
            if (src_ok) begin
              we = 1'b1;
              // A saturated count freezes the total but not min and max.
              if (cur.eaten != '1) begin
                nxt.eaten = cur.eaten + 32'd1;
                nxt.total = cur.total + {32'd0, req_q.delay_value};
              end
              if (req_q.delay_value > cur.max_dly) begin
                nxt.max_dly = req_q.delay_value;
              end
              if (req_q.delay_value < cur.min_dly) begin
                nxt.min_dly = req_q.delay_value;
              end
            end
          end
          psls_pkg::REQ_REPORT: begin
            res_d   = '0;
            state_d = psls_pkg::S_OUT;
            if (!src_ok) begin
              res_d.bad_source = 1'b1;
            end else begin
              res_d.made_count     = cur.made;
              res_d.eaten_count    = cur.eaten;
              res_d.count_mismatch = (cur.made != cur.eaten);
              if (cur.eaten != '0) begin
                res_d.min_delay_out = cur.min_dly;
                res_d.max_delay_out = cur.max_dly;
                div_start           = 1'b1;
                state_d             = psls_pkg::S_DIV;
              end
            end
          end
          default: begin
          end
        endcase
      end
      psls_pkg::S_DIV: begin
        if (div_done) begin
          res_d.avg_delay_out = quotient;
          state_d             = psls_pkg::S_OUT;
        end
      end
      psls_pkg::S_OUT: begin
        if (load) begin
          state_d = psls_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = psls_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psls_pkg::S_IDLE;
      act_q       <= psls_pkg::ACTIVE_RESET;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        act_q <= cfg_data_i;
      end
      if (we) begin
        vld_q[req_q.source_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      req_q <= in_data_i;
      hit_q <= vld_q[in_data_i.source_index];
    end
    if (load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
